### design/xymsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xymsu_pkg
// Shared widths, fixed-point constants and types for the XY model Metropolis
// site update pipeline.
// ----------------------------------------------------------------------------
package xymsu_pkg;

   localparam int ANGLE_WIDTH = 16;
   localparam int AW          = ANGLE_WIDTH;
   localparam int FRAC        = AW - 3;
   localparam int OW          = AW - 1;
   localparam int DW          = AW + 1;
   localparam int RW          = AW - 2;

   localparam int PI_Q     = int'(((64'd205887 << FRAC) + 64'd32768) >> 16);
   localparam int TWO_PI_Q = 2 * PI_Q;

   localparam int QF       = 30;
   localparam int ONE_Q30  = 1 << QF;
   localparam int COS_W    = 32;
   localparam int CSTEPS   = 5;
   localparam int COS_LAT  = 3 + 3 * CSTEPS + 1;

   localparam int ESTEPS   = 12;
   localparam int EMULS    = 11;
   localparam int EXP_LAT  = 3 * ESTEPS + EMULS;
   localparam logic [28:0] EXP_M1_Q30 = 29'd395007542;

   localparam int BETA_W   = 16;
   localparam int U_W      = 16;
   localparam int DS_W     = 35;
   localparam logic [15:0] BETA_RESET = 16'd4096;

   localparam int SIDE_LAST = COS_LAT + 4 + EXP_LAT;
   localparam int SIDE_LEN  = SIDE_LAST + 1;

   typedef struct packed {
      logic                 valid;
      logic signed [AW-1:0] theta;
      logic signed [AW-1:0] old;
      logic [U_W-1:0]       u;
   } side_type;

   typedef struct packed {
      logic force_acc;
      logic force_rej;
   } flag_type;

   function automatic int cos_div(input int j);
      int k;
      case (j)
         0:       k = 90;
         1:       k = 56;
         2:       k = 30;
         3:       k = 12;
         default: k = 2;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

### design/xymsu_cos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xymsu_cos
// Pipelined fixed-point cosine of an angle difference: range reduction,
// quadrant fold, then a five-step Horner series with exact constant divides.
// ----------------------------------------------------------------------------
module xymsu_cos import xymsu_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic signed [DW-1:0]    diff,
   output logic signed [COS_W-1:0]      cos_val
);

   localparam int RDW = DW + 2;
   localparam int XW  = 31;
   localparam logic signed [RDW-1:0] TWO_D = RDW'(TWO_PI_Q);
   localparam logic [AW-1:0] PI_A  = AW'(PI_Q);
   localparam logic [AW-1:0] TWO_A = AW'(TWO_PI_Q);

   logic signed [RDW-1:0] a0, a1, a2;
   logic [AW-1:0]         red_ff;
   logic [AW-1:0]         rr, fr;
   logic                  fneg;
   logic [RW-1:0]         fold_ff;
   logic                  fneg_ff;
   logic [XW-1:0]         xv;
   logic [2*XW-1:0]       xsq;
   logic [31:0]           x2_ff;
   logic                  neg_ff;

   logic [62:0] a_prod [CSTEPS];
   logic [31:0] a_x2   [CSTEPS];
   logic        a_neg  [CSTEPS];
   logic [32:0] b_p    [CSTEPS];
   logic [66:0] b_mq   [CSTEPS];
   logic [31:0] b_x2   [CSTEPS];
   logic        b_neg  [CSTEPS];
   logic signed [31:0] c_t [CSTEPS];
   logic [31:0] c_x2   [CSTEPS];
   logic        c_neg  [CSTEPS];
   logic signed [COS_W-1:0] cos_ff;

   // reduce modulo two pi
   always_comb begin
      a0 = RDW'(diff);
      a1 = (a0 < 0) ? a0 + TWO_D : a0;
      a2 = (a1 < 0) ? a1 + TWO_D : a1;
      if (a2 >= TWO_D) begin
         a2 = a2 - TWO_D;
      end
   end

   // fold into the first quadrant
   always_comb begin
      rr   = (red_ff > PI_A) ? TWO_A - red_ff : red_ff;
      fr   = rr;
      fneg = 1'b0;
      if (({1'b0, rr} << 1) > (AW + 1)'(PI_Q)) begin
         fr   = PI_A - rr;
         fneg = 1'b1;
      end
   end

   always_comb begin
      xv  = XW'(fold_ff) << (QF - FRAC);
      xsq = (2 * XW)'(xv) * (2 * XW)'(xv);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff  <= a2[AW-1:0];
         fold_ff <= fr[RW-1:0];
         fneg_ff <= fneg;
         x2_ff   <= xsq[61:30];
         neg_ff  <= fneg_ff;
      end
   end

   for (genvar j = 0; j < CSTEPS; j++) begin : g_step
      localparam int K = cos_div(j);
      localparam logic [33:0] MAG = 34'((64'd1 << 34) / K);
      logic [30:0] t_i;
      logic [31:0] x2_i;
      logic        neg_i;
      logic [32:0] q0;
      logic [39:0] rem;
      logic [32:0] q;
      logic [33:0] tn;

      if (j == 0) begin : g_first
         assign t_i   = 31'(ONE_Q30);
         assign x2_i  = x2_ff;
         assign neg_i = neg_ff;
      end else begin : g_next
         assign t_i   = c_t[j-1][30:0];
         assign x2_i  = c_x2[j-1];
         assign neg_i = c_neg[j-1];
      end

      always_comb begin
         q0  = b_mq[j][66:34];
         rem = 40'(b_p[j]) - 40'(q0) * 40'(K);
         q   = q0 + 33'(rem >= 40'(K));
         tn  = 34'(ONE_Q30) - 34'(q);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_prod[j] <= 63'(x2_i) * 63'(t_i);
            a_x2[j]   <= x2_i;
            a_neg[j]  <= neg_i;
            b_p[j]    <= a_prod[j][62:30];
            b_mq[j]   <= 67'(a_prod[j][62:30]) * 67'(MAG);
            b_x2[j]   <= a_x2[j];
            b_neg[j]  <= a_neg[j];
            c_t[j]    <= tn[31:0];
            c_x2[j]   <= b_x2[j];
            c_neg[j]  <= b_neg[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= c_neg[CSTEPS-1] ? -c_t[CSTEPS-1] : c_t[CSTEPS-1];
      end
   end

   assign cos_val = cos_ff;

endmodule
`default_nettype wire

### design/xymsu_exp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xymsu_exp
// Pipelined exp(-x) in Q.30: Horner series on the fraction, then one
// conditional multiply by exp(-1) per stage for the integer part.
// ----------------------------------------------------------------------------
module xymsu_exp import xymsu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [29:0] frac_in,
   input  wire logic [3:0]  int_in,
   output logic [30:0]      exp_val
);

   logic [60:0] a_prod [ESTEPS];
   logic [29:0] a_r    [ESTEPS];
   logic [3:0]  a_m    [ESTEPS];
   logic [30:0] b_p    [ESTEPS];
   logic [64:0] b_mq   [ESTEPS];
   logic [29:0] b_r    [ESTEPS];
   logic [3:0]  b_m    [ESTEPS];
   logic [30:0] c_t    [ESTEPS];
   logic [29:0] c_r    [ESTEPS];
   logic [3:0]  c_m    [ESTEPS];
   logic [30:0] e_t    [EMULS];
   logic [3:0]  e_m    [EMULS];

   for (genvar j = 0; j < ESTEPS; j++) begin : g_step
      localparam int K = ESTEPS - j;
      localparam logic [33:0] MAG = 34'((64'd1 << 33) / K);
      logic [30:0] t_i;
      logic [29:0] r_i;
      logic [3:0]  m_i;
      logic [31:0] q0;
      logic [35:0] rem;
      logic [31:0] q;

      if (j == 0) begin : g_first
         assign t_i = 31'(ONE_Q30);
         assign r_i = frac_in;
         assign m_i = int_in;
      end else begin : g_next
         assign t_i = c_t[j-1];
         assign r_i = c_r[j-1];
         assign m_i = c_m[j-1];
      end

      always_comb begin
         q0  = b_mq[j][64:33];
         rem = 36'(b_p[j]) - 36'(q0) * 36'(K);
         q   = q0 + 32'(rem >= 36'(K));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_prod[j] <= 61'(r_i) * 61'(t_i);
            a_r[j]    <= r_i;
            a_m[j]    <= m_i;
            b_p[j]    <= a_prod[j][60:30];
            b_mq[j]   <= 65'(a_prod[j][60:30]) * 65'(MAG);
            b_r[j]    <= a_r[j];
            b_m[j]    <= a_m[j];
            c_t[j]    <= 31'(ONE_Q30) - q[30:0];
            c_r[j]    <= b_r[j];
            c_m[j]    <= b_m[j];
         end
      end
   end

   for (genvar i = 0; i < EMULS; i++) begin : g_mul
      logic [30:0] t_i;
      logic [3:0]  m_i;
      logic [59:0] prod;

      if (i == 0) begin : g_first
         assign t_i = c_t[ESTEPS-1];
         assign m_i = c_m[ESTEPS-1];
      end else begin : g_next
         assign t_i = e_t[i-1];
         assign m_i = e_m[i-1];
      end

      assign prod = 60'(t_i) * 60'(EXP_M1_Q30);

      always_ff @(posedge clock) begin
         if (en) begin
            e_t[i] <= (4'(i) < m_i) ? 31'(prod[59:30]) : t_i;
            e_m[i] <= m_i;
         end
      end
   end

   assign exp_val = e_t[EMULS-1];

endmodule
`default_nettype wire

### design/xy_metropolis_site_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xy_metropolis_site_update
// One Metropolis trial for a spin of the 2D XY model.
// ----------------------------------------------------------------------------
// usage
//   request channel (req_): site angle, four neighbor angles, proposal offset
//   and uniform draw, taken when req_valid is high and req_stall is low.
//   response channel (rsp_): resulting angle and accepted flag, one response
//   per request, in request order.
//   csr port: csr_write_enable writes csr_write_data into beta (Q4.12),
//   reset value 1.0; write only while no request is in flight.
//   pipeline: a request reaches response valid through the 19-stage cosine
//   lanes and the 47-stage exp unit.
//   throughput: one request per cycle while req_stall is low.
//   reset: synchronous, clears all valid bits and sets beta to 1.0.
//   stall: when a response waits under rsp_stall the whole pipeline holds and
//   req_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module xy_metropolis_site_update import xymsu_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic signed [AW-1:0]   req_site_angle,
   input  wire logic signed [AW-1:0]   req_left_angle,
   input  wire logic signed [AW-1:0]   req_right_angle,
   input  wire logic signed [AW-1:0]   req_up_angle,
   input  wire logic signed [AW-1:0]   req_down_angle,
   input  wire logic signed [OW-1:0]   req_proposal_offset,
   input  wire logic [U_W-1:0]         req_uniform_draw,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [AW-1:0]        rsp_new_angle,
   output logic                        rsp_accepted,
   input  wire logic                   csr_write_enable,
   input  wire logic [BETA_W-1:0]      csr_write_data
);

   localparam logic signed [DW-1:0] PI_D = DW'(PI_Q);
   localparam logic [37:0] BIG_X = 38'(12) << QF;

   logic                     en;
   logic [BETA_W-1:0]        beta_ff;

   logic                     s0_valid_ff;
   logic signed [AW-1:0]     s0_site_ff;
   logic signed [AW-1:0]     s0_nb_ff [4];
   logic signed [OW-1:0]     s0_off_ff;
   logic [U_W-1:0]           s0_u_ff;

   logic signed [DW-1:0]     sum_p, sum_m, th;
   side_type                 s1_in;
   side_type                 s1_ff;
   logic signed [AW-1:0]     s1_nb_ff [4];

   side_type                 side_ff [SIDE_LEN];
   logic signed [COS_W-1:0]  cos_new [4];
   logic signed [COS_W-1:0]  cos_old [4];

   logic signed [COS_W:0]    o01_ff, o23_ff, n01_ff, n23_ff;
   logic signed [COS_W+1:0]  so_ff, sn_ff;
   logic signed [DS_W-1:0]   ds_ff;
   logic [49:0]              mul_ff;
   logic                     dsle_ff;
   logic [37:0]              xq;
   logic [29:0]              r_ff;
   logic [3:0]               m_ff;
   flag_type                 fl_in;
   flag_type                 fl_ff [EXP_LAT+1];
   logic [30:0]              exp_t;

   logic                     acc;
   logic                     rsp_valid_ff;
   logic signed [AW-1:0]     rsp_angle_ff;
   logic                     rsp_acc_ff;

   assign en        = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~en;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= BETA_RESET;
      end else if (csr_write_enable) begin
         beta_ff <= csr_write_data;
      end
   end

   // capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_site_ff  <= req_site_angle;
         s0_nb_ff[0] <= req_left_angle;
         s0_nb_ff[1] <= req_right_angle;
         s0_nb_ff[2] <= req_up_angle;
         s0_nb_ff[3] <= req_down_angle;
         s0_off_ff   <= req_proposal_offset;
         s0_u_ff     <= req_uniform_draw;
      end
   end

   // proposal, mirrored when out of range, then clamped
   always_comb begin
      sum_p = DW'(s0_site_ff) + DW'(s0_off_ff);
      sum_m = DW'(s0_site_ff) - DW'(s0_off_ff);
      th    = (sum_p > PI_D || sum_p < -PI_D) ? sum_m : sum_p;
      if (th > PI_D) begin
         th = PI_D;
      end
      if (th < -PI_D) begin
         th = -PI_D;
      end
      s1_in.valid = s0_valid_ff;
      s1_in.theta = th[AW-1:0];
      s1_in.old   = s0_site_ff;
      s1_in.u     = s0_u_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_nb_ff <= s0_nb_ff;
      end
   end

   // cosine lanes
   for (genvar i = 0; i < 4; i++) begin : g_lane
      logic signed [DW-1:0] d_new;
      logic signed [DW-1:0] d_old;

      assign d_new = DW'(s1_ff.theta) - DW'(s1_nb_ff[i]);
      assign d_old = DW'(s1_ff.old) - DW'(s1_nb_ff[i]);

      xymsu_cos u_cos_new (
         .clock   (clock),
         .en      (en),
         .diff    (d_new),
         .cos_val (cos_new[i])
      );

      xymsu_cos u_cos_old (
         .clock   (clock),
         .en      (en),
         .diff    (d_old),
         .cos_val (cos_old[i])
      );
   end

   // side band delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE_LEN; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= s1_ff;
         for (int i = 1; i < SIDE_LEN; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // energy difference and scaling
   always_ff @(posedge clock) begin
      if (en) begin
         o01_ff  <= (COS_W + 1)'(cos_old[0]) + (COS_W + 1)'(cos_old[1]);
         o23_ff  <= (COS_W + 1)'(cos_old[2]) + (COS_W + 1)'(cos_old[3]);
         n01_ff  <= (COS_W + 1)'(cos_new[0]) + (COS_W + 1)'(cos_new[1]);
         n23_ff  <= (COS_W + 1)'(cos_new[2]) + (COS_W + 1)'(cos_new[3]);
         so_ff   <= (COS_W + 2)'(o01_ff) + (COS_W + 2)'(o23_ff);
         sn_ff   <= (COS_W + 2)'(n01_ff) + (COS_W + 2)'(n23_ff);
         ds_ff   <= DS_W'(so_ff) - DS_W'(sn_ff);
         mul_ff  <= 50'(ds_ff[33:0]) * 50'(beta_ff);
         dsle_ff <= (ds_ff <= 0);
      end
   end

   always_comb begin
      xq              = mul_ff[49:12];
      fl_in.force_acc = dsle_ff | (side_ff[COS_LAT+3].u == '0);
      fl_in.force_rej = (xq >= BIG_X);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff     <= xq[29:0];
         m_ff     <= xq[33:30];
         fl_ff[0] <= fl_in;
         for (int i = 1; i <= EXP_LAT; i++) begin
            fl_ff[i] <= fl_ff[i-1];
         end
      end
   end

   xymsu_exp u_exp (
      .clock   (clock),
      .en      (en),
      .frac_in (r_ff),
      .int_in  (m_ff),
      .exp_val (exp_t)
   );

   // acceptance test and response register
   always_comb begin
      acc = fl_ff[EXP_LAT].force_acc |
            (~fl_ff[EXP_LAT].force_rej &
             (exp_t >= (31'(side_ff[SIDE_LAST].u) << 14)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= side_ff[SIDE_LAST].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_angle_ff <= acc ? side_ff[SIDE_LAST].theta : side_ff[SIDE_LAST].old;
         rsp_acc_ff   <= acc;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_angle = rsp_angle_ff;
   assign rsp_accepted  = rsp_acc_ff;

endmodule
`default_nettype wire

### bench/xymsu_checker.sv
// ----------------------------------------------------------------------------
// xymsu_checker
// Watches the request, response and csr ports of the XY Metropolis site
// update, predicts the resulting angle and accepted flag of every request
// and compares them in order with the responses.
// ----------------------------------------------------------------------------
module xymsu_checker import xymsu_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic signed [AW-1:0] req_site_angle,
   input  wire logic signed [AW-1:0] req_left_angle,
   input  wire logic signed [AW-1:0] req_right_angle,
   input  wire logic signed [AW-1:0] req_up_angle,
   input  wire logic signed [AW-1:0] req_down_angle,
   input  wire logic signed [OW-1:0] req_proposal_offset,
   input  wire logic [U_W-1:0]       req_uniform_draw,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic signed [AW-1:0] rsp_new_angle,
   input  wire logic                 rsp_accepted,
   input  wire logic                 csr_write_enable,
   input  wire logic [BETA_W-1:0]    csr_write_data,
   output int                        failures,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint HALF_TURN = ((longint'(205887) << FRAC) + 32768) >>> 16;
   localparam longint UNIT = longint'(1) << 30;
   localparam longint INV_E = 395007542;

   typedef struct {
      logic signed [AW-1:0] angle;
      logic                 taken;
   } trial_type;

   trial_type trials_due[$];
   logic [BETA_W-1:0] beta;

   function automatic longint cosine(input longint d);
      longint r, x, x2, t;
      bit flip;
      r = d % (2 * HALF_TURN);
      flip = 0;
      if (r < 0) r += 2 * HALF_TURN;
      if (r > HALF_TURN) r = 2 * HALF_TURN - r;
      if (2 * r > HALF_TURN) begin
         r = HALF_TURN - r;
         flip = 1;
      end
      x = r * (longint'(1) << (30 - FRAC));
      x2 = (x * x) / UNIT;
      t = UNIT;
      t = UNIT - (x2 * t / UNIT) / 90;
      t = UNIT - (x2 * t / UNIT) / 56;
      t = UNIT - (x2 * t / UNIT) / 30;
      t = UNIT - (x2 * t / UNIT) / 12;
      t = UNIT - (x2 * t / UNIT) / 2;
      return flip ? -t : t;
   endfunction

   function automatic longint site_energy(input longint a, input longint l,
                                          input longint r, input longint u,
                                          input longint d);
      return 4 * UNIT - cosine(a - l) - cosine(a - r) - cosine(a - u) - cosine(a - d);
   endfunction

   function automatic longint decay(input longint x);
      longint m, r, t;
      m = x >>> 30;
      r = x & (UNIT - 1);
      t = UNIT;
      for (int k = 12; k >= 1; k--) t = UNIT - (((r * t) >>> 30) / k);
      for (longint k = 0; k < m; k++) t = (t * INV_E) >>> 30;
      return t;
   endfunction

   function automatic trial_type metropolis_trial();
      longint old, l, r, up, dn, off, theta, ds, x;
      trial_type res;
      old = req_site_angle;
      l = req_left_angle;
      r = req_right_angle;
      up = req_up_angle;
      dn = req_down_angle;
      off = req_proposal_offset;
      theta = old + off;
      if (theta > HALF_TURN || theta < -HALF_TURN) theta = old - off;
      if (theta > HALF_TURN) theta = HALF_TURN;
      if (theta < -HALF_TURN) theta = -HALF_TURN;
      ds = site_energy(theta, l, r, up, dn) - site_energy(old, l, r, up, dn);
      if (ds <= 0 || req_uniform_draw == 0) begin
         res.taken = 1;
      end else begin
         x = (ds * longint'(beta)) >>> 12;
         if (x >= 12 * UNIT) res.taken = 0;
         else res.taken = decay(x) >= (longint'(req_uniform_draw) << 14);
      end
      res.angle = res.taken ? theta[AW-1:0] : req_site_angle;
      return res;
   endfunction

   task automatic report(input string what, input longint want, input longint got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      failures++;
   endtask

   initial failures = 0;
   assign pending = trials_due.size();

   always @(posedge clock) begin
      trial_type want;
      if (reset) begin
         beta = BETA_RESET;
         trials_due.delete();
      end else begin
         if (csr_write_enable) beta = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (trials_due.size() == 0) begin
               $display("unexpected response at %0t", $realtime);
               failures++;
            end else begin
               want = trials_due.pop_front();
               if (rsp_new_angle !== want.angle) report("new_angle", want.angle, rsp_new_angle);
               if (rsp_accepted !== want.taken) report("accepted", want.taken, rsp_accepted);
            end
         end
         if (req_valid && !req_stall) trials_due.push_back(metropolis_trial());
      end
   end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the XY Metropolis site update with directed corner requests and
// random requests over several beta settings, under random sender bursts and
// receiver stalls; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench import xymsu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PI_A = 25736;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [AW-1:0] req_site_angle, req_left_angle, req_right_angle;
   logic signed [AW-1:0] req_up_angle, req_down_angle;
   logic signed [OW-1:0] req_proposal_offset;
   logic [U_W-1:0]       req_uniform_draw;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [AW-1:0] rsp_new_angle;
   logic                 rsp_accepted;
   logic                 csr_write_enable;
   logic [BETA_W-1:0]    csr_write_data;
   int                   failures, pending, cycles, burst_left;
   int                   stall_mode, stall_left, stall_tick;

   xy_metropolis_site_update i_dut (.*);
   xymsu_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("xy_metropolis_site_update test failed");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(10, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         0:       rsp_stall <= 0;
         1:       rsp_stall <= 1'($urandom_range(0, 1));
         2:       rsp_stall <= $urandom_range(0, 3) != 0;
         default: rsp_stall <= stall_tick[2];
      endcase
   end

   task automatic issue(input logic [15:0] site, input logic [15:0] l, input logic [15:0] r,
                        input logic [15:0] up, input logic [15:0] dn,
                        input logic [14:0] off, input logic [15:0] draw);
      req_valid <= 1;
      req_site_angle <= site;
      req_left_angle <= l;
      req_right_angle <= r;
      req_up_angle <= up;
      req_down_angle <= dn;
      req_proposal_offset <= off;
      req_uniform_draw <= draw;
      do @(posedge clock); while (req_stall);
      if (burst_left == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 40);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [15:0] any_angle();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom_range(0, 65535));
         1:       return $urandom_range(0, 1) ? 16'(PI_A) : 16'(-PI_A);
         default: return 16'(int'($urandom_range(0, 2 * PI_A)) - PI_A);
      endcase
   endfunction

   function automatic logic [14:0] any_offset();
      case ($urandom_range(0, 5))
         0:       return 15'($urandom_range(0, 32767));
         1:       return $urandom_range(0, 1) ? 15'(14582) : 15'(-14582);
         2:       return 15'(int'($urandom_range(0, 4000)) - 2000);
         default: return 15'(int'($urandom_range(0, 29164)) - 14582);
      endcase
   endfunction

   function automatic logic [15:0] any_draw();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 16'hffff;
         2:       return 16'($urandom_range(0, 255));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic random_trials(input int count);
      logic [15:0] site, nb;
      for (int i = 0; i < count; i++) begin
         site = any_angle();
         if ($urandom_range(0, 3) == 0) begin
            // ordered neighborhood near the site
            nb = site + 16'(int'($urandom_range(0, 800)) - 400);
            issue(site, nb, nb, nb + 16'($urandom_range(0, 50)), nb, any_offset(), any_draw());
         end else begin
            issue(site, any_angle(), any_angle(), any_angle(), any_angle(),
                  any_offset(), any_draw());
         end
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_beta(input logic [15:0] value);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   initial begin
      reset = 1;
      cycles = 0;
      burst_left = 0;
      stall_mode = 0;
      stall_left = 0;
      stall_tick = 0;
      rsp_stall = 0;
      req_valid = 0;
      req_site_angle = 0;
      req_left_angle = 0;
      req_right_angle = 0;
      req_up_angle = 0;
      req_down_angle = 0;
      req_proposal_offset = 0;
      req_uniform_draw = 0;
      csr_write_enable = 0;
      csr_write_data = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // corners at reset beta
      issue(0, 0, 0, 0, 0, 0, 16'hffff);
      issue(16'(PI_A), 16'(PI_A), 16'(PI_A), 16'(PI_A), 16'(PI_A), 15'd14582, 16'hffff);
      issue(16'(-PI_A), 16'(-PI_A), 16'(-PI_A), 16'(-PI_A), 16'(-PI_A),
            15'(-14582), 16'hffff);
      issue(0, 0, 0, 0, 0, 15'd14582, 16'hffff);
      issue(0, 0, 0, 0, 0, 15'd14582, 0);
      issue(0, 0, 0, 0, 0, 15'd100, 16'd1);
      issue(16'd20000, 0, 0, 0, 0, 15'd10000, 16'hffff);
      issue(16'd20000, 0, 0, 0, 0, 15'(-10000), 16'hffff);
      issue(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 15'h3fff, 16'h8000);
      issue(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 15'h4000, 16'h8000);
      issue(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h1234, 15'h2aaa, 16'h5555);
      issue(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'hedcb, 15'h5555, 16'haaaa);
      issue(16'd25000, 16'd25000, 16'd25000, 16'd25000, 16'd25000, 15'd1000, 16'd30000);
      issue(16'd12868, 16'd12868, 16'd12868, 16'd12868, 16'd12868, 15'd6434, 16'd200);
      random_trials(60);

      // full hold-off until everything has come back
      set_beta(16'd0);
      issue(0, 0, 0, 0, 0, 15'd14582, 16'hffff);
      random_trials(70);
      set_beta(16'hffff);
      issue(0, 0, 0, 0, 0, 15'd14582, 16'd1);
      issue(0, 0, 0, 0, 0, 15'd30, 16'd1);
      random_trials(70);
      set_beta(16'd1);
      random_trials(60);
      set_beta(16'($urandom_range(0, 65535)));
      random_trials(60);
      set_beta(16'd512);
      random_trials(60);
      set_beta(16'd4096);
      random_trials(60);

      drain();
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("xy_metropolis_site_update test passed");
      end else begin
         $display("xy_metropolis_site_update test failed");
      end
      $finish;
   end

endmodule

### sim.f
design/xymsu_pkg.sv
design/xymsu_cos.sv
design/xymsu_exp.sv
design/xy_metropolis_site_update.sv
bench/xymsu_checker.sv
bench/testbench.sv
